// ----- design/mre_pkg.sv -----
// Shared types and constants for the multimodal rotary embedding unit.
// No dependencies; every other design file imports this package.
package mre_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned LANE_W  = 6;
	localparam int unsigned CFG_W   = 7;
	localparam int unsigned ENTRY_W = 2 * DATA_W;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_T_SPAN      = 3'd0;
	localparam cfg_idx_t CFG_H_SPAN      = 3'd1;
	localparam cfg_idx_t CFG_W_SPAN      = 3'd2;
	localparam cfg_idx_t CFG_INTERLEAVED = 3'd3;
	localparam cfg_idx_t CFG_HALF_DIM    = 3'd4;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_ROTATE = 1'b1;

	typedef struct packed {
		logic                     func;
		logic [POS_W-1:0]         entry_pos;
		logic [POS_W-1:0]         t_pos;
		logic [POS_W-1:0]         h_pos;
		logic [POS_W-1:0]         w_pos;
		logic [LANE_W-1:0]        lane;
		logic signed [DATA_W-1:0] x_in;
		logic signed [DATA_W-1:0] y_in;
		logic signed [DATA_W-1:0] cos_value;
		logic signed [DATA_W-1:0] sin_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x_out;
		logic signed [DATA_W-1:0] y_out;
		logic                     lane_outside;
		logic                     saturated;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] t_span;
		logic [CFG_W-1:0] h_span;
		logic [CFG_W-1:0] w_span;
		logic             interleaved;
		logic [CFG_W-1:0] half_dim;
	} cfg_t;

	// What kind of item travels down the pipeline.
	typedef struct packed {
		logic write;
		logic outside;
	} kind_t;

endpackage

// ----- design/multimodal_rotary_embedding_unit.sv -----
// Multimodal rotary embedding unit: top level with handshake and config registers.
// Depends on mre_pkg, mre_addr, mre_table and mre_rotate.
//
// Each transfer on req either writes one cos/sin entry (func = 0) or rotates one
// Q8.8 pair (func = 1) by the entry addressed by the lane's chosen position
// (time, height or width, by contiguous sections or by lane mod 3) and the
// lane; exactly one transfer on rsp follows each req transfer, in order.
// Takes one item per cycle unless rsp_ready stalls; each item passes table read,
// four 16x16 products and round/saturate into the output register. The table
// is a single-port memory of 2^(clog2(MAX_POSITIONS)+clog2(MAX_HALF_DIM))
// 32-bit words; a write is done at its own req transfer, so a later rotate
// always sees it. Entries have no reset: write every entry a rotate will use.
// Configuration registers may be written only while the unit holds no item.
module multimodal_rotary_embedding_unit import mre_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = 256,
	parameter int unsigned MAX_HALF_DIM  = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int unsigned ROW_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int unsigned COL_W  = (MAX_HALF_DIM > 1) ? $clog2(MAX_HALF_DIM) : 1;
	localparam int unsigned ADDR_W = ROW_W + COL_W;

	cfg_t                     cfg_q;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic                     en_s1;
	logic                     en_s2;
	logic                     en_s3;
	logic                     accept;
	logic [ADDR_W-1:0]        addr;
	logic                     outside;
	kind_t                    kind_s1;
	logic signed [DATA_W-1:0] x_s1;
	logic signed [DATA_W-1:0] y_s1;
	logic [ENTRY_W-1:0]       entry_s1;
	logic                     tbl_we;
	logic                     tbl_re;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t_span      <= '0;
			cfg_q.h_span      <= '0;
			cfg_q.w_span      <= '0;
			cfg_q.interleaved <= 1'b0;
			cfg_q.half_dim    <= CFG_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_T_SPAN:      cfg_q.t_span      <= cfg_wdata;
				CFG_H_SPAN:      cfg_q.h_span      <= cfg_wdata;
				CFG_W_SPAN:      cfg_q.w_span      <= cfg_wdata;
				CFG_INTERLEAVED: cfg_q.interleaved <= cfg_wdata[0];
				CFG_HALF_DIM:    cfg_q.half_dim    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Per-stage enables: a stage advances when it is empty or its successor
	// advances, so bubbles close up while the output waits.
	assign en_s3     = !valid_s3 || rsp_ready;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign req_ready = en_s1;
	assign accept    = req_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= req_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	mre_addr #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.MAX_HALF_DIM  (MAX_HALF_DIM)
	) u_addr (
		.req     (req),
		.cfg     (cfg_q),
		.addr    (addr),
		.outside (outside)
	);

	// Write the table at the write's own transfer; read only for real rotations.
	assign tbl_we = accept && (req.func == FUNC_WRITE);
	assign tbl_re = accept && (req.func == FUNC_ROTATE) && !outside;

	mre_table #(
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.re    (tbl_re),
		.addr  (addr),
		.wdata ({req.sin_value, req.cos_value}),
		.rdata (entry_s1)
	);

	// Stage 1 payload, aligned with the table's read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1.write   <= (req.func == FUNC_WRITE);
			kind_s1.outside <= outside;
			x_s1            <= req.x_in;
			y_s1            <= req.y_in;
		end
	end

	mre_rotate u_rotate (
		.clk      (clk),
		.en_s2    (en_s2),
		.en_s3    (en_s3),
		.kind_s1  (kind_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.entry_s1 (entry_s1),
		.rsp_s3   (rsp)
	);

	assign rsp_valid = valid_s3;

endmodule

// ----- design/mre_addr.sv -----
// Position selection and table address generation for one item.
// Depends on mre_pkg.
module mre_addr import mre_pkg::*; #(
	parameter int unsigned MAX_POSITIONS = 256,
	parameter int unsigned MAX_HALF_DIM  = 64,
	localparam int unsigned ROW_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1,
	localparam int unsigned COL_W  = (MAX_HALF_DIM > 1) ? $clog2(MAX_HALF_DIM) : 1,
	localparam int unsigned ADDR_W = ROW_W + COL_W
) (
	input  req_t                     req,
	input  cfg_t                     cfg,
	output logic [ADDR_W-1:0]        addr,
	output logic                     outside
);

	localparam int unsigned N_POS  = 2 ** POS_W;
	localparam int unsigned N_LANE = 2 ** LANE_W;

	logic [ROW_W-1:0] pos_wrap  [N_POS];
	logic [COL_W-1:0] lane_wrap [N_LANE];

	// Constant wrap tables for position and lane indices.
	for (genvar g = 0; g < N_POS; g++) begin : g_pos_wrap
		localparam int unsigned R = g % MAX_POSITIONS;
		assign pos_wrap[g] = ROW_W'(R);
	end

	for (genvar g = 0; g < N_LANE; g++) begin : g_lane_wrap
		localparam int unsigned R = g % MAX_HALF_DIM;
		assign lane_wrap[g] = COL_W'(R);
	end

	logic [11:0]       lane_prod;
	logic [4:0]        lane_q;
	logic [7:0]        lane_r;
	logic [1:0]        lane_mod3;
	logic [8:0]        h_limit;
	logic [8:0]        w_limit;
	logic [7:0]        h_end;
	logic [7:0]        lane8;
	logic              h_sel;
	logic              w_sel;
	logic [POS_W-1:0]  pos;

	always_comb begin
		// lane / 3 by reciprocal: exact for six-bit lanes
		lane_prod = 12'(req.lane) * 12'd43;
		lane_q    = lane_prod[11:7];
		lane_r    = {2'b00, req.lane} - ({3'b000, lane_q} + {2'b00, lane_q, 1'b0});
		lane_mod3 = lane_r[1:0];

		h_limit = {2'b00, cfg.h_span} + {1'b0, cfg.h_span, 1'b0};
		w_limit = {2'b00, cfg.w_span} + {1'b0, cfg.w_span, 1'b0};
		h_end   = {1'b0, cfg.t_span} + {1'b0, cfg.h_span};
		lane8   = {2'b00, req.lane};
		outside = ({1'b0, req.lane} >= cfg.half_dim);

		if (cfg.interleaved) begin
			h_sel = (lane_mod3 == 2'd1) && ({3'b000, req.lane} < h_limit);
			w_sel = (lane_mod3 == 2'd2) && ({3'b000, req.lane} < w_limit);
		end else begin
			h_sel = ({1'b0, cfg.t_span} <= lane8) && (lane8 < h_end);
			w_sel = (h_end <= lane8) && !outside;
		end

		if (req.func == FUNC_WRITE) begin
			pos = req.entry_pos;
		end else if (h_sel) begin
			pos = req.h_pos;
		end else if (w_sel) begin
			pos = req.w_pos;
		end else begin
			pos = req.t_pos;
		end

		addr = {pos_wrap[pos], lane_wrap[req.lane]};
	end

endmodule

// ----- design/mre_table.sv -----
// Cos/sin table: single-port synchronous memory with a registered read.
// Depends on mre_pkg.
module mre_table import mre_pkg::*; #(
	parameter int unsigned ADDR_W = 14
) (
	input  logic               clk,
	input  logic               we,
	input  logic               re,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [ENTRY_W-1:0] wdata,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [2**ADDR_W];

	// Hold read data while the pipeline stalls.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- design/mre_rotate.sv -----
// Rotation datapath: product stage, then round/saturate into the output register.
// Depends on mre_pkg.
module mre_rotate import mre_pkg::*; (
	input  logic                     clk,
	input  logic                     en_s2,
	input  logic                     en_s3,
	input  kind_t                    kind_s1,
	input  logic signed [DATA_W-1:0] x_s1,
	input  logic signed [DATA_W-1:0] y_s1,
	input  logic [ENTRY_W-1:0]       entry_s1,
	output rsp_t                     rsp_s3
);

	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned ACC_W  = PROD_W + 1;
	localparam int unsigned FRAC   = 14;
	localparam int unsigned RES_W  = ACC_W - FRAC;

	logic signed [DATA_W-1:0] cos_s1;
	logic signed [DATA_W-1:0] sin_s1;

	kind_t                    kind_s2;
	logic signed [DATA_W-1:0] x_s2;
	logic signed [DATA_W-1:0] y_s2;
	logic signed [PROD_W-1:0] xc_s2;
	logic signed [PROD_W-1:0] ys_s2;
	logic signed [PROD_W-1:0] yc_s2;
	logic signed [PROD_W-1:0] xs_s2;

	logic signed [ACC_W-1:0]  x_acc;
	logic signed [ACC_W-1:0]  y_acc;
	logic signed [RES_W-1:0]  x_rnd;
	logic signed [RES_W-1:0]  y_rnd;
	logic [DATA_W:0]          x_sat;
	logic [DATA_W:0]          y_sat;
	rsp_t                     rsp_d;

	// Saturate to 16 bits; top bit of the result flags a clip.
	function automatic logic [DATA_W:0] sat16(input logic signed [RES_W-1:0] v);
		logic [DATA_W:0] r;
		if (v > RES_W'(32767)) begin
			r = {1'b1, 16'h7FFF};
		end else if (v < -RES_W'(32768)) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

	assign cos_s1 = $signed(entry_s1[DATA_W-1:0]);
	assign sin_s1 = $signed(entry_s1[ENTRY_W-1:DATA_W]);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2 <= kind_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			xc_s2   <= x_s1 * cos_s1;
			ys_s2   <= y_s1 * sin_s1;
			yc_s2   <= y_s1 * cos_s1;
			xs_s2   <= x_s1 * sin_s1;
		end
	end

	always_comb begin
		x_acc = ACC_W'(xc_s2) - ACC_W'(ys_s2) + ACC_W'(8192);
		y_acc = ACC_W'(yc_s2) + ACC_W'(xs_s2) + ACC_W'(8192);
		x_rnd = x_acc[ACC_W-1:FRAC];
		y_rnd = y_acc[ACC_W-1:FRAC];
		x_sat = sat16(x_rnd);
		y_sat = sat16(y_rnd);

		if (kind_s2.write) begin
			rsp_d = '0;
		end else if (kind_s2.outside) begin
			rsp_d.x_out        = x_s2;
			rsp_d.y_out        = y_s2;
			rsp_d.lane_outside = 1'b1;
			rsp_d.saturated    = 1'b0;
		end else begin
			rsp_d.x_out        = x_sat[DATA_W-1:0];
			rsp_d.y_out        = y_sat[DATA_W-1:0];
			rsp_d.lane_outside = 1'b0;
			rsp_d.saturated    = x_sat[DATA_W] | y_sat[DATA_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rsp_s3 <= rsp_d;
		end
	end

endmodule

// ----- dv/tb_multimodal_rotary_embedding_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for multimodal_rotary_embedding_unit (directed and random traffic).
// Depends on mre_pkg and the unit's RTL; keeps its own cos/sin table and lane-selection model.

module tb_multimodal_rotary_embedding_unit;
	import mre_pkg::*;

	localparam int unsigned LANE_GROUP = 3;   // interleaved mode cycles t, h, w by lane mod 3
	localparam int unsigned FRAC_BITS  = 14;  // Q1.14 cos/sin fraction
	localparam longint      ROUND_HALF = longint'(1) << (FRAC_BITS - 1);
	localparam int unsigned LATENCY    = 3;
	localparam int unsigned MAX_SHOWN  = 10;
	localparam int unsigned TABLE_SIZE = 1 << (POS_W + LANE_W);

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	cfg_idx_t         cfg_index = CFG_T_SPAN;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;

	// Mirror of the unit: register settings and the cos/sin table ({sin, cos} per word).
	cfg_t        cur_cfg = '{t_span: '0, h_span: '0, w_span: '0,
		interleaved: 1'b0, half_dim: 7'd64};
	logic [31:0] cs_table [TABLE_SIZE];
	// Entries that a write has been issued for; rotates only ever read these.
	bit          seeded [TABLE_SIZE];

	rsp_t rotated_q [$];   // results still owed by the unit, oldest first
	int   failures = 0;
	bit   steady   = 1'b0; // set to run both sides without idle cycles

	multimodal_rotary_embedding_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Position that a lane rotates by under the current settings.
	function automatic logic [POS_W-1:0] lane_position(req_t r);
		int unsigned ln;
		int unsigned h_end;
		bit          h_sel;
		bit          w_sel;
		ln = 32'(r.lane);
		if (cur_cfg.interleaved) begin
			// every third lane belongs to h or w, but only inside that section's groups
			h_sel = (ln % LANE_GROUP == 1) && (ln < LANE_GROUP * cur_cfg.h_span);
			w_sel = (ln % LANE_GROUP == 2) && (ln < LANE_GROUP * cur_cfg.w_span);
		end else begin
			// t | h | w back to back; width runs up to half_dim, not the width span
			h_end = 32'(cur_cfg.t_span) + 32'(cur_cfg.h_span);
			h_sel = (cur_cfg.t_span <= ln) && (ln < h_end);
			w_sel = (h_end <= ln) && (ln < cur_cfg.half_dim);
		end
		if (h_sel)
			return r.h_pos;
		if (w_sel)
			return r.w_pos;
		return r.t_pos;
	endfunction

	// Round half toward +inf, drop the fraction, clip to 16 bits; bit 16 flags a clip.
	function automatic logic [DATA_W:0] round_sat(longint acc);
		longint q;
		q = (acc + ROUND_HALF) >>> FRAC_BITS;
		if (q > 32767)
			return {1'b1, 16'h7fff};
		if (q < -32768)
			return {1'b1, 16'h8000};
		return {1'b0, q[DATA_W-1:0]};
	endfunction

	// Apply one accepted item to the mirror and return the result it must produce.
	function automatic rsp_t rotate_or_store(req_t r);
		rsp_t             o;
		logic [31:0]      e;
		longint           xv, yv, cv, sv;
		logic [DATA_W:0]  xr, yr;
		o = '0;
		if (r.func == FUNC_WRITE) begin
			// stored whatever half_dim says; the result is all zero
			cs_table[{r.entry_pos, r.lane}] = {r.sin_value, r.cos_value};
			return o;
		end
		if (r.lane >= cur_cfg.half_dim) begin
			// pass the pair through untouched, no table read
			o.x_out        = r.x_in;
			o.y_out        = r.y_in;
			o.lane_outside = 1'b1;
			return o;
		end
		e  = cs_table[{lane_position(r), r.lane}];
		xv = $signed(r.x_in);
		yv = $signed(r.y_in);
		cv = $signed(e[DATA_W-1:0]);
		sv = $signed(e[2*DATA_W-1:DATA_W]);
		xr = round_sat(xv * cv - yv * sv);
		yr = round_sat(yv * cv + xv * sv);
		o.x_out     = xr[DATA_W-1:0];
		o.y_out     = yr[DATA_W-1:0];
		o.saturated = xr[DATA_W] | yr[DATA_W];
		return o;
	endfunction

	task automatic flag_failure(string what);
		failures++;
		if (failures <= MAX_SHOWN)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Monitor: predict at every req transfer, check at every rsp transfer.
	// Both are sampled at the edge, before the edge's own updates land.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n) begin
			if (req_valid && req_ready)
				rotated_q.push_back(rotate_or_store(req));
			if (rsp_valid && rsp_ready) begin
				if (rotated_q.size() == 0) begin
					flag_failure($sformatf("result with nothing outstanding: x %0d y %0d",
						$signed(rsp.x_out), $signed(rsp.y_out)));
				end else begin
					exp_rsp = rotated_q.pop_front();
					if (rsp.x_out !== exp_rsp.x_out || rsp.y_out !== exp_rsp.y_out ||
						rsp.lane_outside !== exp_rsp.lane_outside ||
						rsp.saturated !== exp_rsp.saturated)
						flag_failure($sformatf(
							"expected x %0d y %0d out %b sat %b, got x %0d y %0d out %b sat %b",
							$signed(exp_rsp.x_out), $signed(exp_rsp.y_out),
							exp_rsp.lane_outside, exp_rsp.saturated,
							$signed(rsp.x_out), $signed(rsp.y_out),
							rsp.lane_outside, rsp.saturated));
				end
			end
		end
	end

	// Receiver: may drop ready before taking each result, unless steady is set.
	initial begin : rsp_side
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Hold valid and payload until the transfer; valid stays high into a back-to-back item.
	task automatic send_item(req_t item);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (item.func == FUNC_WRITE)
			seeded[{item.entry_pos, item.lane}] = 1'b1;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic logic [POS_W-1:0] pick_pos();
		// half the time stay in a small pool so entries get reused
		return POS_W'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255));
	endfunction

	function automatic req_t random_item();
		req_t r;
		r.func      = 1'($urandom_range(0, 1));
		r.entry_pos = pick_pos();
		r.t_pos     = pick_pos();
		r.h_pos     = pick_pos();
		r.w_pos     = pick_pos();
		r.lane      = LANE_W'($urandom_range(0, 63));
		r.x_in      = DATA_W'($urandom);
		r.y_in      = DATA_W'($urandom);
		r.cos_value = DATA_W'($urandom_range(0, 32768) - 16384);
		r.sin_value = DATA_W'($urandom_range(0, 32768) - 16384);
		return r;
	endfunction

	function automatic req_t make_item(logic func, logic [POS_W-1:0] pos, logic [LANE_W-1:0] lane,
		logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y,
		logic signed [DATA_W-1:0] c, logic signed [DATA_W-1:0] s);
		req_t r;
		r = '{func: func, entry_pos: pos, t_pos: pos, h_pos: pos, w_pos: pos, lane: lane,
			x_in: x, y_in: y, cos_value: c, sin_value: s};
		return r;
	endfunction

	// Rotate a pair; first fill the entry it will read if nothing has been written there.
	task automatic send_rotate(req_t r);
		req_t             fill;
		logic [POS_W-1:0] p;
		r.func = FUNC_ROTATE;
		if (r.lane < cur_cfg.half_dim) begin
			p = lane_position(r);
			if (!seeded[{p, r.lane}]) begin
				fill           = random_item();
				fill.func      = FUNC_WRITE;
				fill.entry_pos = p;
				fill.lane      = r.lane;
				send_item(fill);
			end
		end
		send_item(r);
	endtask

	// Drop valid, wait for every owed result, then let the pipeline go quiet.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (rotated_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Write all five registers on consecutive edges; only call while idle.
	task automatic apply_config(cfg_t c);
		put_reg(CFG_T_SPAN, c.t_span);
		put_reg(CFG_H_SPAN, c.h_span);
		put_reg(CFG_W_SPAN, c.w_span);
		put_reg(CFG_INTERLEAVED, {{(CFG_W-1){1'b0}}, c.interleaved});
		put_reg(CFG_HALF_DIM, c.half_dim);
		cfg_we  <= 1'b0;
		cur_cfg  = c;
	endtask

	function automatic cfg_t setting(int t, int h, int w, bit il, int hd);
		cfg_t c;
		c.t_span      = CFG_W'(t);
		c.h_span      = CFG_W'(h);
		c.w_span      = CFG_W'(w);
		c.interleaved = il;
		c.half_dim    = CFG_W'(hd);
		return c;
	endfunction

	// Push a few rotates through chosen lanes with random data and positions.
	task automatic probe_lanes(logic [LANE_W-1:0] lanes [$]);
		req_t r;
		foreach (lanes[i]) begin
			r      = random_item();
			r.lane = lanes[i];
			send_rotate(r);
		end
	endtask

	// Reset settings (contiguous, empty t and h, so every lane uses w_pos): table write
	// extremes, saturation both ways, half rounding and the negation overflow.
	task automatic test_arith_extremes();
		send_item(make_item(FUNC_WRITE, 8'd255, 6'd63, 16'sh7fff, 16'sh8000,
			16'sd16384, -16'sd16384));
		send_item(make_item(FUNC_WRITE, 8'd0, 6'd0, 16'sh8000, 16'sh7fff,
			16'sd16384, 16'sd16384));
		send_item(make_item(FUNC_WRITE, 8'd1, 6'd0, '0, '0, 16'sd8192, '0));
		send_item(make_item(FUNC_WRITE, 8'd2, 6'd5, '0, '0, -16'sd16384, '0));
		// x - y and y + x with full-scale inputs: clip high, then clip low
		send_item(make_item(FUNC_ROTATE, 8'd0, 6'd0, 16'sh7fff, 16'sh8000, '0, '0));
		send_item(make_item(FUNC_ROTATE, 8'd0, 6'd0, 16'sh8000, 16'sh7fff, '0, '0));
		// cos of one half on +-1 LSB: exact halves round up
		send_item(make_item(FUNC_ROTATE, 8'd1, 6'd0, 16'sd1, -16'sd1, '0, '0));
		send_item(make_item(FUNC_ROTATE, 8'd255, 6'd63, 16'sh8000, 16'sh8000, '0, '0));
		// -1.0 times the most negative value overflows to +32768 and clips
		send_item(make_item(FUNC_ROTATE, 8'd2, 6'd5, 16'sh8000, '0, '0, '0));
	endtask

	// Boundaries of the t|h|w split and lanes at and beyond half_dim.
	task automatic test_contiguous_sections();
		settle();
		apply_config(setting(10, 20, 7, 1'b0, 48));
		probe_lanes('{6'd9, 6'd10, 6'd29, 6'd30, 6'd47, 6'd48, 6'd63});
	endtask

	// Lane mod 3 picks h or w only inside the group limits.
	task automatic test_interleaved_groups();
		settle();
		apply_config(setting(33, 8, 5, 1'b1, 64));
		probe_lanes('{6'd0, 6'd1, 6'd2, 6'd14, 6'd17, 6'd22, 6'd25});
	endtask

	// Smallest half_dim with full sections, then interleaved with the largest sections.
	task automatic test_config_extremes();
		settle();
		apply_config(setting(64, 64, 64, 1'b0, 1));
		probe_lanes('{6'd0, 6'd1, 6'd63});
		settle();
		apply_config(setting(0, 64, 64, 1'b1, 64));
		probe_lanes('{6'd61, 6'd62, 6'd63});
	endtask

	function automatic int pick_section();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 64;
			default: return $urandom_range(0, 64);
		endcase
	endfunction

	function automatic int pick_half_dim();
		case ($urandom_range(0, 3))
			0: return 1;
			1: return 64;
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// Phases of mixed writes and rotates, each under fresh random settings.
	task automatic test_random_traffic();
		req_t r;
		for (int phase = 0; phase < 10; phase++) begin
			settle();
			apply_config(setting(pick_section(), pick_section(), pick_section(),
				1'($urandom_range(0, 1)), pick_half_dim()));
			steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 80; n++) begin
				r = random_item();
				if (r.func == FUNC_WRITE && $urandom_range(0, 1))
					send_item(r);
				else
					send_rotate(r);
			end
			steady = 1'b0;
		end
	endtask

	initial begin : run
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arith_extremes();
		test_contiguous_sections();
		test_interleaved_groups();
		test_config_extremes();
		test_random_traffic();
		settle();
		if (failures == 0)
			$display("tb_multimodal_rotary_embedding_unit OK");
		else
			$display("tb_multimodal_rotary_embedding_unit NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#2_000_000;
		$display("tb_multimodal_rotary_embedding_unit NOT OK");
		$finish;
	end

endmodule
